[design/lfpd_pkg.sv]
// Shared types, widths and constants for the line follower PID drive block.
// Used by every module of the block; depends on nothing else.
package lfpd_pkg;

    // Sample and result field widths.
    localparam int LFPD_SENSORS = 5;
    localparam int SENSOR_W     = 10;
    localparam int POS_W        = 12;
    localparam int ERR_W        = 12;
    localparam int INTEG_W      = 16;
    localparam int DRIVE_W      = 9;
    localparam int SPEED_W      = 8;
    localparam int GAIN_W       = 16;
    localparam int LIMIT_W      = 15;
    localparam int BAND_W       = 11;

    // Configuration port geometry.
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // Line position geometry: 2000 is dead center, 4000 is the far edge.
    localparam logic [POS_W-1:0] POS_MAX    = 12'd4000;
    localparam logic [POS_W:0]   POS_CENTER = 13'd2000;

    // Q4.12 gains: the PID sum carries 12 fraction bits.
    localparam int FRAC_BITS = 12;
    localparam int PID_LIMIT = 1000;

    // Register reset values.
    localparam logic [SPEED_W-1:0]  RST_BASE_SPEED     = 8'd200;
    localparam logic [GAIN_W-1:0]   RST_PROP_GAIN      = 16'd1229;
    localparam logic [GAIN_W-1:0]   RST_INTEGRAL_GAIN  = 16'd8;
    localparam logic [GAIN_W-1:0]   RST_DERIV_GAIN     = 16'd4915;
    localparam logic [LIMIT_W-1:0]  RST_INTEGRAL_LIMIT = 15'd5000;
    localparam logic [SENSOR_W-1:0] RST_LOST_LEVEL     = 10'd980;
    localparam logic [SPEED_W-1:0]  RST_SPIN_SPEED     = 8'd120;
    localparam logic [BAND_W-1:0]   RST_CENTERED_BAND  = 11'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_SPEED     = 3'd0,
        REG_PROP_GAIN      = 3'd1,
        REG_INTEGRAL_GAIN  = 3'd2,
        REG_DERIV_GAIN     = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_LOST_LEVEL     = 3'd5,
        REG_SPIN_SPEED     = 3'd6,
        REG_CENTERED_BAND  = 3'd7
    } lfpd_reg_idx_t;

    typedef struct packed {
        logic [SPEED_W-1:0]  base_speed;
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integral_gain;
        logic [GAIN_W-1:0]   deriv_gain;
        logic [LIMIT_W-1:0]  integral_limit;
        logic [SENSOR_W-1:0] lost_level;
        logic [SPEED_W-1:0]  spin_speed;
        logic [BAND_W-1:0]   centered_band;
    } lfpd_cfg_t;

    typedef struct packed {
        logic                      searching;
        logic                      centered;
        logic signed [DRIVE_W-1:0] right_drive;
        logic signed [DRIVE_W-1:0] left_drive;
    } lfpd_result_t;

endpackage

[design/lfpd_cfg_regs.sv]
// Configuration register file of the line follower PID drive block.
// Depends on lfpd_pkg for the register indexes, widths and reset values.
module lfpd_cfg_regs
    import lfpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output lfpd_cfg_t             cfg
);

    lfpd_cfg_t cfg_reg;
    lfpd_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (lfpd_reg_idx_t'(cfg_addr))
                REG_BASE_SPEED:     cfg_next.base_speed     = cfg_wdata[SPEED_W-1:0];
                REG_PROP_GAIN:      cfg_next.prop_gain      = cfg_wdata[GAIN_W-1:0];
                REG_INTEGRAL_GAIN:  cfg_next.integral_gain  = cfg_wdata[GAIN_W-1:0];
                REG_DERIV_GAIN:     cfg_next.deriv_gain     = cfg_wdata[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_wdata[LIMIT_W-1:0];
                REG_LOST_LEVEL:     cfg_next.lost_level     = cfg_wdata[SENSOR_W-1:0];
                REG_SPIN_SPEED:     cfg_next.spin_speed     = cfg_wdata[SPEED_W-1:0];
                REG_CENTERED_BAND:  cfg_next.centered_band  = cfg_wdata[BAND_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_speed     <= RST_BASE_SPEED;
            cfg_reg.prop_gain      <= RST_PROP_GAIN;
            cfg_reg.integral_gain  <= RST_INTEGRAL_GAIN;
            cfg_reg.deriv_gain     <= RST_DERIV_GAIN;
            cfg_reg.integral_limit <= RST_INTEGRAL_LIMIT;
            cfg_reg.lost_level     <= RST_LOST_LEVEL;
            cfg_reg.spin_speed     <= RST_SPIN_SPEED;
            cfg_reg.centered_band  <= RST_CENTERED_BAND;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/lfpd_pid_core.sv]
// PID arithmetic and loop state (integral and last error) of the line follower.
// Depends on lfpd_pkg; computes one result per sample in a single pass.
module lfpd_pid_core
    import lfpd_pkg::*;
#(
    parameter int SENSORS = LFPD_SENSORS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  lfpd_cfg_t                          cfg,
    input  logic [SENSORS-1:0][SENSOR_W-1:0]   sensor,
    input  logic [POS_W-1:0]                   line_position,
    input  logic                               advance,
    output lfpd_result_t                       result
);

    localparam int SUM_W = 34;
    localparam int PID_W = SUM_W - FRAC_BITS;
    localparam int WHL_W = 12;

    logic signed [INTEG_W-1:0] integral_sum_reg;
    logic signed [INTEG_W-1:0] integral_sum_next;
    logic signed [ERR_W-1:0]   last_error_reg;

    logic                      lost;
    logic [POS_W-1:0]          pos_sat;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W:0]   integ_raw;
    logic signed [INTEG_W:0]   integ_lim;
    logic signed [ERR_W:0]     deriv;
    logic signed [28:0]        prod_p;
    logic signed [32:0]        prod_i;
    logic signed [29:0]        prod_d;
    logic signed [SUM_W-1:0]   pid_sum;
    logic signed [SUM_W-1:0]   pid_round;
    logic signed [PID_W-1:0]   pid_full;
    logic signed [WHL_W-1:0]   pid;
    logic signed [WHL_W-1:0]   left_raw;
    logic signed [WHL_W-1:0]   right_raw;
    logic [BAND_W-1:0]         err_mag;
    logic signed [DRIVE_W-1:0] spin_pos;
    logic signed [DRIVE_W-1:0] left_run;
    logic signed [DRIVE_W-1:0] right_run;

    // A sample is lost only when every sensor sees bright floor.
    always_comb
    begin
        lost = 1'b1;
        for (int i = 0; i < SENSORS; i++)
        begin
            if (sensor[i] < cfg.lost_level)
                lost = 1'b0;
        end
    end

    assign pos_sat = (line_position > POS_MAX) ? POS_MAX : line_position;
    assign err     = ERR_W'($signed(POS_CENTER) - $signed({1'b0, pos_sat}));

    // Integral with symmetric clamp.
    assign integ_raw = {integral_sum_reg[INTEG_W-1], integral_sum_reg} + (INTEG_W+1)'(err);
    assign integ_lim = $signed({2'b00, cfg.integral_limit});

    always_comb
    begin
        priority if (integ_raw < -integ_lim)
            integral_sum_next = INTEG_W'(-integ_lim);
        else if (integ_raw > integ_lim)
            integral_sum_next = INTEG_W'(integ_lim);
        else
            integral_sum_next = INTEG_W'(integ_raw);
    end

    assign deriv = (ERR_W+1)'(err) - (ERR_W+1)'(last_error_reg);

    assign prod_p = $signed({1'b0, cfg.prop_gain}) * err;
    assign prod_i = $signed({1'b0, cfg.integral_gain}) * integral_sum_next;
    assign prod_d = $signed({1'b0, cfg.deriv_gain}) * deriv;

    assign pid_sum = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

    // Divide by 4096 truncating toward zero: bias negative sums before the shift.
    assign pid_round = pid_sum[SUM_W-1] ? (pid_sum + SUM_W'((1 << FRAC_BITS) - 1)) : pid_sum;
    assign pid_full  = PID_W'(pid_round >>> FRAC_BITS);

    always_comb
    begin
        priority if (pid_full > PID_W'(PID_LIMIT))
            pid = WHL_W'(PID_LIMIT);
        else if (pid_full < -PID_W'(PID_LIMIT))
            pid = -WHL_W'(PID_LIMIT);
        else
            pid = WHL_W'(pid_full);
    end

    assign left_raw  = $signed({4'b0000, cfg.base_speed}) - pid;
    assign right_raw = $signed({4'b0000, cfg.base_speed}) + pid;

    always_comb
    begin
        priority if (left_raw < 0)
            left_run = '0;
        else if (left_raw > WHL_W'(255))
            left_run = DRIVE_W'(255);
        else
            left_run = DRIVE_W'(left_raw);

        priority if (right_raw < 0)
            right_run = '0;
        else if (right_raw > WHL_W'(255))
            right_run = DRIVE_W'(255);
        else
            right_run = DRIVE_W'(right_raw);
    end

    assign err_mag  = err[ERR_W-1] ? BAND_W'(-err) : BAND_W'(err);
    assign spin_pos = $signed({1'b0, cfg.spin_speed});

    always_comb
    begin
        if (lost)
        begin
            // Spin toward the side where the line was last seen.
            result.searching = 1'b1;
            result.centered  = 1'b0;
            if (last_error_reg > 0)
            begin
                result.left_drive  = -spin_pos;
                result.right_drive = spin_pos;
            end
            else
            begin
                result.left_drive  = spin_pos;
                result.right_drive = -spin_pos;
            end
        end
        else
        begin
            result.searching   = 1'b0;
            result.centered    = (err_mag < cfg.centered_band);
            result.left_drive  = left_run;
            result.right_drive = right_run;
        end
    end

    // Loop state moves only when a sample with a visible line is retired.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_sum_reg <= '0;
            last_error_reg   <= '0;
        end
        else if (advance && !lost)
        begin
            integral_sum_reg <= integral_sum_next;
            last_error_reg   <= err;
        end
    end

endmodule

[design/line_follow_pid_drive.sv]
// Top level of the line follower PID drive block: stream ports, input and
// result registers. Depends on lfpd_pkg, lfpd_cfg_regs and lfpd_pid_core.
//
// Usage:
// Sensor samples arrive on the s_axis channel, one sample per beat. Each beat
// carries five reflectance readings and the weighted line position. For every
// accepted beat exactly one beat leaves on the m_axis channel with the signed
// left and right wheel speeds and the centered flag in tdata, and the
// searching flag in tuser.
// The accepting edge loads the input register, the PID arithmetic runs in a
// single pass between the input and result registers, and the result register
// then loads the result once it is empty or its beat is leaving, raising
// m_axis_tvalid. Throughput is one beat per cycle while the receiver does not
// stall; the loop state (error integral and last error) is updated in the same
// cycle a result is loaded, so back-to-back samples each see the state left by the one before.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more sample; s_axis_tready drops only once both
// are full, so nothing is lost or repeated.
// Reset clears both pipeline valid bits, zeroes the integral and last error
// and loads every configuration register with its default. The configuration
// port (cfg_we, cfg_addr, cfg_wdata) writes one register per cycle and should
// only be used while no beat is in flight.
module line_follow_pid_drive
    import lfpd_pkg::*;
#(
    parameter int SENSORS = LFPD_SENSORS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0 up: sensor_0 .. sensor_(SENSORS-1) (10 bits each),
    // line_position (12 bits), zero padding to a whole byte.
    input  logic [(((SENSORS*SENSOR_W+POS_W)+7)/8)*8-1:0] s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0 up: left_drive (9 bits signed), right_drive (9 bits
    // signed), centered (1 bit), zero padding to 24 bits.
    output logic [23:0]           m_axis_tdata,
    // Fields from bit 0 up: searching (1 bit).
    output logic                  m_axis_tuser
);

    localparam int SENS_BITS = SENSORS * SENSOR_W;
    localparam int IN_BITS   = SENS_BITS + POS_W;

    lfpd_cfg_t                        cfg;
    lfpd_result_t                     core_result;

    logic                             in_valid_reg;
    logic [SENSORS-1:0][SENSOR_W-1:0] sensor_reg;
    logic [POS_W-1:0]                 position_reg;
    logic                             out_valid_reg;
    lfpd_result_t                     result_reg;

    logic                             in_take;
    logic                             out_load;

    // The result register loads whenever a sample waits and the register is empty or its beat is leaving.
    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    lfpd_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lfpd_pid_core #(
        .SENSORS (SENSORS)
    ) u_pid_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .sensor        (sensor_reg),
        .line_position (position_reg),
        .advance       (out_load),
        .result        (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (out_load)
                in_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sensor_reg   <= s_axis_tdata[SENS_BITS-1:0];
            position_reg <= s_axis_tdata[IN_BITS-1:SENS_BITS];
        end
        if (out_load)
            result_reg <= core_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, result_reg.centered,
                            result_reg.right_drive, result_reg.left_drive};
    assign m_axis_tuser  = result_reg.searching;

    // While searching, the wheels turn in opposite directions at equal speed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.searching
        |-> (DRIVE_W'(result_reg.left_drive + result_reg.right_drive) == '0))
        else $error("search beat without opposite wheel speeds");

    // A tracking result never commands reverse.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.searching
        |-> (!result_reg.left_drive[DRIVE_W-1] && !result_reg.right_drive[DRIVE_W-1]))
        else $error("tracking beat commands reverse");

    // A search result is never marked centered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.searching |-> !result_reg.centered)
        else $error("search beat marked centered");

    // A waiting sample stays in the input register until it is moved on.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_load |=> in_valid_reg && $stable(position_reg))
        else $error("waiting sample dropped from input register");

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(result_reg))
        else $error("stalled result changed");

endmodule

[dv/line_follow_pid_drive_tb.sv]
// Self-checking testbench for line_follow_pid_drive: it streams sensor samples
// through the block, predicts each wheel command and compares every result beat.
// Depends on lfpd_pkg and the line_follow_pid_drive RTL.
`timescale 1ns / 100ps

module line_follow_pid_drive_tb;

    import lfpd_pkg::*;

    // The sample beat is five readings and the position, padded to whole bytes.
    localparam int S_W        = (((LFPD_SENSORS * SENSOR_W + POS_W) + 7) / 8) * 8;
    localparam int SENSOR_TOP = (1 << SENSOR_W) - 1;
    localparam int POS_TOP    = (1 << POS_W) - 1;
    localparam int WHEEL_MAX  = (1 << SPEED_W) - 1;
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 200;

    // One sensor sample, packed the way s_axis_tdata carries it:
    // sensor[0] in the lowest bits, the line position on top.
    typedef struct packed {
        logic [POS_W-1:0]                       position;
        logic [LFPD_SENSORS-1:0][SENSOR_W-1:0]  sensor;
    } sample_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // Fields from bit 0 up: sensor_0 .. sensor_4 (10 bits each),
    // line_position (12 bits), zero padding.
    logic [S_W-1:0]        s_axis_tdata = '0;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // Fields from bit 0 up: left_drive (9 bits signed), right_drive (9 bits
    // signed), centered (1 bit), zero padding.
    logic [23:0]           m_axis_tdata;
    // Fields from bit 0 up: searching (1 bit).
    logic                  m_axis_tuser;

    // Samples waiting to be offered, and the wheel commands still owed by the block.
    sample_t      sample_queue[$];
    lfpd_result_t drive_expected[$];
    sample_t      offered;

    // The predictor's own copy of the registers and of the loop state.
    lfpd_cfg_t    ctl;
    int           integ_acc;
    int           prev_err;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           pressure_go = 1'b0;
    logic         hold_off = 1'b0;
    int           mismatches = 0;

    line_follow_pid_drive i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Prints one line per mismatch (the first hundred) and counts them all.
    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Works out the wheel command for one accepted sample and advances the
    // integral and last error exactly as the block must.
    function automatic lfpd_result_t steer_predict(sample_t smp);
        lfpd_result_t r;
        bit           lost;
        int           i;
        int           pos;
        int           err;
        int           slope;
        int           lim;
        int           left;
        int           right;
        int           mag;
        longint       acc;
        longint       corr;
        r = '0;
        lost = 1'b1;
        for (i = 0; i < LFPD_SENSORS; i++)
            if (smp.sensor[i] < ctl.lost_level)
                lost = 1'b0;

        if (lost)
        begin
            // Line lost: spin toward the side where the line was last seen.
            // The loop state is left alone and centered stays low.
            if (prev_err > 0)
            begin
                left  = -int'(ctl.spin_speed);
                right = int'(ctl.spin_speed);
            end
            else
            begin
                left  = int'(ctl.spin_speed);
                right = -int'(ctl.spin_speed);
            end
            r.left_drive  = left[DRIVE_W-1:0];
            r.right_drive = right[DRIVE_W-1:0];
            r.searching   = 1'b1;
            return r;
        end

        // Positions past the far edge saturate there.
        pos = (smp.position > POS_MAX) ? int'(POS_MAX) : int'(smp.position);
        err = int'(POS_CENTER) - pos;

        lim = int'(ctl.integral_limit);
        integ_acc = integ_acc + err;
        if (integ_acc > lim)
            integ_acc = lim;
        if (integ_acc < -lim)
            integ_acc = -lim;
        slope = err - prev_err;
        prev_err = err;

        // Q4.12 gains: the sum is exact, then truncated toward zero.
        acc = longint'(ctl.prop_gain) * err + longint'(ctl.integral_gain) * integ_acc
            + longint'(ctl.deriv_gain) * slope;
        corr = acc / longint'(1 << FRAC_BITS);
        if (corr > PID_LIMIT)
            corr = PID_LIMIT;
        if (corr < -PID_LIMIT)
            corr = -PID_LIMIT;

        left  = int'(ctl.base_speed) - int'(corr);
        right = int'(ctl.base_speed) + int'(corr);
        if (left < 0)
            left = 0;
        if (left > WHEEL_MAX)
            left = WHEEL_MAX;
        if (right < 0)
            right = 0;
        if (right > WHEEL_MAX)
            right = WHEEL_MAX;
        mag = (err < 0) ? -err : err;

        r.left_drive  = left[DRIVE_W-1:0];
        r.right_drive = right[DRIVE_W-1:0];
        r.centered    = (mag < int'(ctl.centered_band));
        return r;
    endfunction

    // Sample source. A beat stays on the bus until it is taken; a new one is
    // offered only once the slot is free, unless this cycle is an idle one.
    // Prediction happens at the accepting edge, so it sees the state left by
    // every sample accepted before.
    always @(posedge clk)
    begin : sample_driver
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                drive_expected.push_back(steer_predict(offered));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = sample_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= S_W'(offered);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result sink. Each accepted beat is checked field by field against the
    // oldest outstanding prediction; ready is rerolled every cycle.
    always @(posedge clk)
    begin : result_monitor
        lfpd_result_t got;
        lfpd_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata[18:0]};
                if (drive_expected.size() == 0)
                begin
                    report_mismatch("unrequested result beat", int'(got), 0);
                end
                else
                begin
                    want = drive_expected.pop_front();
                    if (got.left_drive !== want.left_drive)
                        report_mismatch("left_drive", got.left_drive, want.left_drive);
                    if (got.right_drive !== want.right_drive)
                        report_mismatch("right_drive", got.right_drive, want.right_drive);
                    if (got.centered !== want.centered)
                        report_mismatch("centered", got.centered, want.centered);
                    if (got.searching !== want.searching)
                        report_mismatch("searching", got.searching, want.searching);
                end
            end
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // One long receiver hold-off while the sender keeps offering, so that both
    // pipeline stages fill and the block has to drop s_axis_tready.
    initial
    begin : pressure_window
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Ends a run that hangs, for instance on a result beat that never comes.
    initial
    begin : watchdog
        #2_400_000;
        $display("line_follow_pid_drive_tb: FAIL");
        $finish;
    end

    // Writes one register and mirrors it, trimmed to its width, in the
    // predictor's copy. Only called while nothing is in flight.
    task automatic write_reg(lfpd_reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_BASE_SPEED:     ctl.base_speed     = val[SPEED_W-1:0];
            REG_PROP_GAIN:      ctl.prop_gain      = val[GAIN_W-1:0];
            REG_INTEGRAL_GAIN:  ctl.integral_gain  = val[GAIN_W-1:0];
            REG_DERIV_GAIN:     ctl.deriv_gain     = val[GAIN_W-1:0];
            REG_INTEGRAL_LIMIT: ctl.integral_limit = val[LIMIT_W-1:0];
            REG_LOST_LEVEL:     ctl.lost_level     = val[SENSOR_W-1:0];
            REG_SPIN_SPEED:     ctl.spin_speed     = val[SPEED_W-1:0];
            REG_CENTERED_BAND:  ctl.centered_band  = val[BAND_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_settings(int base, int kp, int ki, int kd, int lim, int lost,
                                 int spin, int band);
        write_reg(REG_BASE_SPEED, CFG_DATA_W'(base));
        write_reg(REG_PROP_GAIN, CFG_DATA_W'(kp));
        write_reg(REG_INTEGRAL_GAIN, CFG_DATA_W'(ki));
        write_reg(REG_DERIV_GAIN, CFG_DATA_W'(kd));
        write_reg(REG_INTEGRAL_LIMIT, CFG_DATA_W'(lim));
        write_reg(REG_LOST_LEVEL, CFG_DATA_W'(lost));
        write_reg(REG_SPIN_SPEED, CFG_DATA_W'(spin));
        write_reg(REG_CENTERED_BAND, CFG_DATA_W'(band));
    endtask

    // Waits until every queued sample went in and every result came out,
    // then lets the pipeline settle.
    task automatic wait_drained();
        while (sample_queue.size() != 0 || s_axis_tvalid || drive_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic sample_t flat_sample(int level, int pos);
        sample_t s;
        int      i;
        for (i = 0; i < LFPD_SENSORS; i++)
            s.sensor[i] = SENSOR_W'(level);
        s.position = POS_W'(pos);
        return s;
    endfunction

    // Random sample around a target position. A lost sample has every reading
    // at or above the lost level; otherwise, unless the lost level is zero, at least one reading sees the line.
    function automatic sample_t make_sample(bit want_lost, int aim);
        sample_t s;
        int      i;
        int      p;
        for (i = 0; i < LFPD_SENSORS; i++)
            s.sensor[i] = want_lost ? SENSOR_W'($urandom_range(SENSOR_TOP, ctl.lost_level))
                                    : SENSOR_W'($urandom_range(SENSOR_TOP));
        if (!want_lost && ctl.lost_level != 0)
            s.sensor[$urandom_range(LFPD_SENSORS - 1)] =
                SENSOR_W'($urandom_range(ctl.lost_level - 1));
        if ($urandom_range(9) == 0)
        begin
            p = $urandom_range(POS_TOP);
        end
        else
        begin
            p = aim + int'($urandom_range(1600)) - 800;
            if (p < 0)
                p = 0;
            if (p > int'(POS_MAX))
                p = int'(POS_MAX);
        end
        s.position = POS_W'(p);
        return s;
    endfunction

    initial
    begin : stimulus
        sample_t s;
        int      phase;
        int      n;
        int      aim;
        ctl = '{base_speed: RST_BASE_SPEED, prop_gain: RST_PROP_GAIN,
                integral_gain: RST_INTEGRAL_GAIN, deriv_gain: RST_DERIV_GAIN,
                integral_limit: RST_INTEGRAL_LIMIT, lost_level: RST_LOST_LEVEL,
                spin_speed: RST_SPIN_SPEED, centered_band: RST_CENTERED_BAND};
        integ_acc = 0;
        prev_err  = 0;
        aim = int'(POS_CENTER);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset settings: position extremes, both edges
        // of the centered band, searching after a positive, negative and zero
        // last error, the lost level exactly and one count below it, and long
        // runs that drive the integral into its negative clamp and back up.
        sample_queue.push_back(flat_sample(0, 2000));
        sample_queue.push_back(flat_sample(0, 0));
        sample_queue.push_back(flat_sample(0, 4000));
        sample_queue.push_back(flat_sample(0, POS_TOP));
        sample_queue.push_back(flat_sample(0, 1700));
        sample_queue.push_back(flat_sample(0, 1701));
        sample_queue.push_back(flat_sample(0, 2300));
        sample_queue.push_back(flat_sample(0, 2299));
        sample_queue.push_back(flat_sample(SENSOR_TOP, 123));
        sample_queue.push_back(flat_sample(0, 0));
        sample_queue.push_back(flat_sample(980, 3000));
        s = flat_sample(980, 2000);
        s.sensor[LFPD_SENSORS - 1] = SENSOR_W'(979);
        sample_queue.push_back(s);
        sample_queue.push_back(flat_sample(1000, 500));
        for (n = 0; n < 4; n++)
            sample_queue.push_back(flat_sample(0, 4001));
        for (n = 0; n < 4; n++)
            sample_queue.push_back(flat_sample(0, 0));
        s = flat_sample(0, POS_TOP);
        s.sensor[0] = SENSOR_W'(SENSOR_TOP);
        s.sensor[2] = SENSOR_W'(SENSOR_TOP);
        s.sensor[4] = SENSOR_W'(SENSOR_TOP);
        sample_queue.push_back(s);
        sample_queue.push_back(flat_sample(SENSOR_TOP, 0));
        wait_drained();

        // Random part: each phase brings new settings and a new idling pattern.
        // Samples come in runs around one target so the integral builds up.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: load_settings(RST_BASE_SPEED, RST_PROP_GAIN, RST_INTEGRAL_GAIN,
                                 RST_DERIV_GAIN, RST_INTEGRAL_LIMIT, RST_LOST_LEVEL,
                                 RST_SPIN_SPEED, RST_CENTERED_BAND);
                1: load_settings(WHEEL_MAX, 65535, 65535, 65535, 32767, SENSOR_TOP,
                                 WHEEL_MAX, (1 << BAND_W) - 1);
                2: load_settings(0, 0, 0, 0, 0, 0, 0, 0);
                5: load_settings(0, $urandom_range(8000), $urandom_range(200),
                                 $urandom_range(16000), $urandom_range(8000), 1000,
                                 $urandom_range(WHEEL_MAX), 2000);
                // Full 16-bit values: the bits above each register's width
                // must be dropped.
                6: load_settings($urandom_range(65535), $urandom_range(65535),
                                 $urandom_range(65535), $urandom_range(65535),
                                 $urandom_range(65535), $urandom_range(65535),
                                 $urandom_range(65535), $urandom_range(65535));
                default: load_settings($urandom_range(WHEEL_MAX), $urandom_range(12000),
                                       $urandom_range(400), $urandom_range(20000),
                                       $urandom_range(32767), $urandom_range(1000, 700),
                                       $urandom_range(WHEEL_MAX), $urandom_range(2000));
            endcase

            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 56;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 56;
                end
                default:
                begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            if (phase == 4)
                pressure_go = 1'b1;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 20 == 0)
                begin
                    case ($urandom_range(3))
                        0: aim = 300;
                        1: aim = int'(POS_CENTER);
                        2: aim = 3700;
                        default: aim = $urandom_range(int'(POS_MAX));
                    endcase
                end
                sample_queue.push_back(make_sample($urandom_range(99) < 12, aim));
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("line_follow_pid_drive_tb: PASS");
        else
            $display("line_follow_pid_drive_tb: FAIL");
        $finish;
    end

endmodule
